// File: design/tbvs_pkg.sv
package tbvs_pkg;

    localparam int NUM_BONES    = 32;
    localparam int MAX_VERTICES = 255;
    localparam int SLOT_WORDS   = 12;
    localparam int TABLE_WORDS  = (NUM_BONES + 1) * SLOT_WORDS;
    localparam int ADDR_W       = 9;
    localparam int SLOT_W       = $clog2(NUM_BONES + 1);
    localparam int BONE_W       = 5;
    localparam int W_W          = 17;
    localparam int WD_W         = 18;
    localparam int CNT_W        = 8;
    localparam int SUM_W        = 48;
    localparam int ACC_W        = 68;
    localparam int Q_SHIFT      = 16;
    localparam int IN_DATA_W    = 184;
    localparam int OUT_DATA_W   = 192;
    localparam int OUT_USER_W   = 2;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    localparam logic [W_W-1:0] Q16_ONE = 17'd65536;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(32'sh0000_8000);
    localparam logic signed [ACC_W-1:0] S32_MAX  = ACC_W'(32'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] S32_MIN  = ACC_W'(32'sh8000_0000);

    typedef struct packed {
        logic                     kind;
        logic                     last;
        logic                     idx_ok;
        logic [ADDR_W-1:0]        word_index;
        logic signed [31:0]       word_value;
        logic [W_W-1:0]           wa;
        logic [W_W-1:0]           wb;
        logic signed [WD_W-1:0]   wd;
        logic [SLOT_W-1:0]        slot_a;
        logic [SLOT_W-1:0]        slot_b;
        logic signed [31:0]       pos_x;
        logic signed [31:0]       pos_y;
        logic signed [31:0]       pos_z;
    } t_item;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > S32_MAX) begin
            return 32'sh7FFF_FFFF;
        end else if (v < S32_MIN) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // sign/magnitude quotient back to saturated two's complement
    function automatic logic signed [31:0] sat_mean(input logic neg,
                                                    input logic [SUM_W-1:0] q);
        if (!neg) begin
            if (q > SUM_W'(32'h7FFF_FFFF)) begin
                return 32'sh7FFF_FFFF;
            end
            return q[31:0];
        end
        if (q > SUM_W'(32'h8000_0000)) begin
            return 32'sh8000_0000;
        end
        return -q[31:0];
    endfunction

endpackage

// File: design/tbvs_front.sv
module tbvs_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // word_index, word_value, weight_a, weight_b, bone_a, bone_b, pos_x, pos_y, pos_z
    input  logic [tbvs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // kind
    input  logic                               s_axis_tuser,
    input  logic                               s_axis_tlast,
    output logic                               o_q_valid,
    output tbvs_pkg::t_item                    o_q_item,
    input  logic                               i_q_pop
);

    logic [tbvs_pkg::W_W-1:0]    wa_raw, wb_raw, wa, wb;
    logic [tbvs_pkg::BONE_W-1:0] bone_a, bone_b;
    tbvs_pkg::t_item             n_item;
    tbvs_pkg::t_item             r_buf [2];
    logic [1:0]                  r_count;
    logic                        r_wp, r_rp;
    logic                        push;

    assign wa_raw = s_axis_tdata[57:41];
    assign wb_raw = s_axis_tdata[74:58];
    assign bone_a = s_axis_tdata[79:75];
    assign bone_b = s_axis_tdata[84:80];
    assign wa = (wa_raw > tbvs_pkg::Q16_ONE) ? tbvs_pkg::Q16_ONE : wa_raw;
    assign wb = (wb_raw > tbvs_pkg::Q16_ONE) ? tbvs_pkg::Q16_ONE : wb_raw;

    always_comb begin
        n_item.kind       = s_axis_tuser;
        n_item.last       = s_axis_tlast;
        n_item.word_index = s_axis_tdata[8:0];
        n_item.idx_ok     = (32'(s_axis_tdata[8:0]) < tbvs_pkg::TABLE_WORDS);
        n_item.word_value = s_axis_tdata[40:9];
        n_item.wa         = wa;
        n_item.wb         = wb;
        n_item.wd         = $signed({1'b0, tbvs_pkg::Q16_ONE}) - $signed({1'b0, wa})
                            - $signed({1'b0, wb});
        // out-of-range bones fall back to the default slot
        n_item.slot_a     = ({27'b0, bone_a} >= 32'(tbvs_pkg::NUM_BONES)) ?
                            tbvs_pkg::SLOT_W'(tbvs_pkg::NUM_BONES) :
                            tbvs_pkg::SLOT_W'(bone_a);
        n_item.slot_b     = ({27'b0, bone_b} >= 32'(tbvs_pkg::NUM_BONES)) ?
                            tbvs_pkg::SLOT_W'(tbvs_pkg::NUM_BONES) :
                            tbvs_pkg::SLOT_W'(bone_b);
        n_item.pos_x      = s_axis_tdata[116:85];
        n_item.pos_y      = s_axis_tdata[148:117];
        n_item.pos_z      = s_axis_tdata[180:149];
    end

    assign s_axis_tready = (r_count != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_q_valid     = (r_count != 2'd0);
    assign o_q_item      = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !i_q_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!push && i_q_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= n_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("queue count overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_count != 2'd0) else $error("pop from empty queue");

endmodule

// File: design/tbvs_back.sv
module tbvs_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_wdata,
    input  logic                               i_q_valid,
    input  tbvs_pkg::t_item                    i_q_item,
    output logic                               o_q_pop,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [tbvs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic [tbvs_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MACA  = 4'd1;
    localparam logic [3:0] S_WAITA = 4'd2;
    localparam logic [3:0] S_MACB  = 4'd3;
    localparam logic [3:0] S_WAITB = 4'd4;
    localparam logic [3:0] S_ACC   = 4'd5;
    localparam logic [3:0] S_DINIT = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    localparam int ELEMS  = tbvs_pkg::SLOT_WORDS;
    localparam int STEP_W = $clog2(tbvs_pkg::SUM_W);

    logic [3:0]                         r_state;
    logic                               r_enable;
    tbvs_pkg::t_item                    r_item;
    logic [3:0]                         r_e;
    logic [1:0]                         r_j, r_r, r_c;

    logic [31:0]                        mem [tbvs_pkg::TABLE_WORDS];
    logic signed [31:0]                 r_rdata;
    logic                               mem_we, mem_re;
    logic [tbvs_pkg::ADDR_W-1:0]        rd_addr;
    logic [tbvs_pkg::SLOT_W-1:0]        slot_sel;
    logic signed [tbvs_pkg::WD_W-1:0]   w_sel;

    logic                               r_t1_v, r_t1_first, r_t1_fin;
    logic signed [tbvs_pkg::WD_W-1:0]   r_t1_w;
    logic [3:0]                         r_t1_idx;

    logic                               r_t2_v, r_t2_ph, r_t2_first, r_t2_fin;
    logic [3:0]                         r_t2_idx;
    logic signed [31:0]                 r_t2_e3;
    logic signed [63:0]                 r_prod;
    logic signed [31:0]                 mul_a, mul_b, pos_sel;
    logic                               mul_v;

    logic signed [tbvs_pkg::ACC_W-1:0]  r_acc, acc_base, acc_sum;
    logic                               r_f_v, r_f_ph;
    logic [3:0]                         r_f_idx;
    logic signed [tbvs_pkg::ACC_W-1:0]  r_f_acc, fin_rnd;
    logic signed [31:0]                 r_f_e3;

    logic signed [31:0]                 r_mat [ELEMS];
    logic signed [31:0]                 r_res [3];
    logic                               r_avgv, r_def;

    logic signed [tbvs_pkg::SUM_W-1:0]  r_sum [3];
    logic [tbvs_pkg::CNT_W-1:0]         r_cnt;

    logic [tbvs_pkg::SUM_W-1:0]         r_dq [3];
    logic [tbvs_pkg::CNT_W-1:0]         r_drem [3];
    logic                               r_dneg [3];
    logic [tbvs_pkg::CNT_W-1:0]         r_dn;
    logic [STEP_W-1:0]                  r_dstep;
    logic [tbvs_pkg::CNT_W:0]           div_sh [3];
    logic                               div_ge [3];
    logic [tbvs_pkg::SUM_W-1:0]         sum_mag [3];

    logic                               r_ovalid;
    logic [tbvs_pkg::OUT_DATA_W-1:0]    r_odata;
    logic [tbvs_pkg::OUT_USER_W-1:0]    r_ouser;
    logic                               out_load;
    logic signed [31:0]                 avg_val [3];

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign mem_we  = o_q_pop && (i_q_item.kind == tbvs_pkg::KIND_LOAD) && i_q_item.idx_ok;
    assign mem_re  = (r_state == S_MACA);

    // term 0: bone a, term 1: bone b, term 2: default slot
    always_comb begin
        case (r_j)
            2'd0: begin
                slot_sel = r_item.slot_a;
                w_sel    = $signed({1'b0, r_item.wa});
            end
            2'd1: begin
                slot_sel = r_item.slot_b;
                w_sel    = $signed({1'b0, r_item.wb});
            end
            default: begin
                slot_sel = tbvs_pkg::SLOT_W'(tbvs_pkg::NUM_BONES);
                w_sel    = r_item.wd;
            end
        endcase
        rd_addr = tbvs_pkg::ADDR_W'(slot_sel) * tbvs_pkg::ADDR_W'(ELEMS)
                  + tbvs_pkg::ADDR_W'(r_e);
    end

    always_comb begin
        case (r_c)
            2'd0:    pos_sel = r_item.pos_x;
            2'd1:    pos_sel = r_item.pos_y;
            default: pos_sel = r_item.pos_z;
        endcase
    end

    // shared multiplier: blend terms, then matrix-times-point
    assign mul_v = r_t1_v || (r_state == S_MACB);
    assign mul_a = r_t1_v ? ((r_t1_w == '0) ? 32'sd0 : r_rdata) : r_mat[0];
    assign mul_b = r_t1_v ? 32'(r_t1_w) : pos_sel;

    assign acc_base = r_t2_first ? '0 : r_acc;
    assign acc_sum  = acc_base + tbvs_pkg::ACC_W'(r_prod);
    assign fin_rnd  = (r_f_acc + tbvs_pkg::RND_HALF) >>> tbvs_pkg::Q_SHIFT;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            div_sh[i]  = {r_drem[i], r_dq[i][tbvs_pkg::SUM_W-1]};
            div_ge[i]  = (div_sh[i] >= {1'b0, r_dn});
            sum_mag[i] = r_sum[i][tbvs_pkg::SUM_W-1] ? tbvs_pkg::SUM_W'(-r_sum[i]) :
                         tbvs_pkg::SUM_W'(r_sum[i]);
            avg_val[i] = r_avgv ? tbvs_pkg::sat_mean(r_dneg[i], r_dq[i]) : 32'sd0;
        end
    end

    assign out_load = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[i_q_item.word_index] <= i_q_item.word_value;
        end
        if (mem_re) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_enable <= 1'b0;
            r_t1_v   <= 1'b0;
            r_t2_v   <= 1'b0;
            r_f_v    <= 1'b0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            r_t1_v <= mem_re;
            r_t2_v <= mul_v;
            r_f_v  <= r_t2_v && r_t2_fin;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_q_pop && i_q_item.kind == tbvs_pkg::KIND_VERTEX) begin
                        if (r_enable) begin
                            r_state <= S_MACA;
                        end else begin
                            r_state <= S_OUT;
                            if (i_q_item.last) begin
                                r_cnt <= '0;
                                for (int i = 0; i < 3; i++) begin
                                    r_sum[i] <= '0;
                                end
                            end
                        end
                    end
                end
                S_MACA: begin
                    if (r_j == 2'd2 && r_e == 4'(ELEMS - 1)) begin
                        r_state <= S_WAITA;
                    end
                end
                S_WAITA: begin
                    if (r_f_v && !r_f_ph && r_f_idx == 4'(ELEMS - 1)) begin
                        r_state <= S_MACB;
                    end
                end
                S_MACB: begin
                    if (r_c == 2'd2 && r_r == 2'd2) begin
                        r_state <= S_WAITB;
                    end
                end
                S_WAITB: begin
                    if (r_f_v && r_f_ph && r_f_idx == 4'd2) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (r_cnt < tbvs_pkg::CNT_W'(tbvs_pkg::MAX_VERTICES)) begin
                        r_cnt <= r_cnt + 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            r_sum[i] <= r_sum[i] + tbvs_pkg::SUM_W'(r_res[i]);
                        end
                    end
                    r_state <= r_item.last ? S_DINIT : S_OUT;
                end
                S_DINIT: begin
                    r_cnt <= '0;
                    for (int i = 0; i < 3; i++) begin
                        r_sum[i] <= '0;
                    end
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_dstep == STEP_W'(tbvs_pkg::SUM_W - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
            r_e    <= '0;
            r_j    <= '0;
            r_r    <= '0;
            r_c    <= '0;
            r_res[0] <= i_q_item.pos_x;
            r_res[1] <= i_q_item.pos_y;
            r_res[2] <= i_q_item.pos_z;
            r_avgv   <= 1'b0;
            r_def    <= 1'b0;
        end
        if (r_state == S_MACA) begin
            if (r_j == 2'd2) begin
                r_j <= '0;
                r_e <= r_e + 4'd1;
            end else begin
                r_j <= r_j + 2'd1;
            end
        end
        r_t1_w     <= w_sel;
        r_t1_first <= (r_j == 2'd0);
        r_t1_fin   <= (r_j == 2'd2);
        r_t1_idx   <= r_e;

        r_prod <= mul_a * mul_b;
        if (r_t1_v) begin
            r_t2_ph    <= 1'b0;
            r_t2_first <= r_t1_first;
            r_t2_fin   <= r_t1_fin;
            r_t2_idx   <= r_t1_idx;
        end else begin
            r_t2_ph    <= 1'b1;
            r_t2_first <= (r_c == 2'd0);
            r_t2_fin   <= (r_c == 2'd2);
            r_t2_idx   <= {2'b00, r_r};
        end
        // row's translation sits one behind the tap on the last column
        r_t2_e3 <= r_mat[1];

        if (r_state == S_MACB) begin
            if (r_c == 2'd2) begin
                r_c <= '0;
                r_r <= r_r + 2'd1;
                for (int i = 0; i < ELEMS - 2; i++) begin
                    r_mat[i] <= r_mat[i + 2];
                end
            end else begin
                r_c <= r_c + 2'd1;
                for (int i = 0; i < ELEMS - 1; i++) begin
                    r_mat[i] <= r_mat[i + 1];
                end
            end
        end

        if (r_t2_v) begin
            r_acc <= acc_sum;
        end
        r_f_acc <= acc_sum;
        r_f_ph  <= r_t2_ph;
        r_f_idx <= r_t2_idx;
        r_f_e3  <= r_t2_e3;

        if (r_f_v) begin
            if (!r_f_ph) begin
                r_mat[r_f_idx] <= tbvs_pkg::sat32(fin_rnd);
            end else begin
                r_res[r_f_idx[1:0]] <= tbvs_pkg::sat32(fin_rnd
                                       + tbvs_pkg::ACC_W'(r_f_e3));
            end
        end

        if (r_state == S_ACC) begin
            r_def  <= 1'b1;
            r_avgv <= r_item.last;
        end

        if (r_state == S_DINIT) begin
            r_dn    <= r_cnt;
            r_dstep <= '0;
            for (int i = 0; i < 3; i++) begin
                r_dneg[i] <= r_sum[i][tbvs_pkg::SUM_W-1];
                r_dq[i]   <= sum_mag[i] + tbvs_pkg::SUM_W'(r_cnt >> 1);
                r_drem[i] <= '0;
            end
        end
        if (r_state == S_DIV) begin
            r_dstep <= r_dstep + 1'b1;
            for (int i = 0; i < 3; i++) begin
                r_dq[i]   <= {r_dq[i][tbvs_pkg::SUM_W-2:0], div_ge[i]};
                r_drem[i] <= div_ge[i] ? tbvs_pkg::CNT_W'(div_sh[i] - {1'b0, r_dn}) :
                             tbvs_pkg::CNT_W'(div_sh[i]);
            end
        end

        if (out_load) begin
            r_odata <= {avg_val[2], avg_val[1], avg_val[0], r_res[2], r_res[1], r_res[0]};
            r_ouser <= {r_def, r_avgv};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    a_table_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> r_state == S_IDLE) else $error("table write outside idle");
    a_blend_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f_v && !r_f_ph) |-> (r_state == S_MACA || r_state == S_WAITA))
        else $error("blend result outside blend phase");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= tbvs_pkg::CNT_W'(tbvs_pkg::MAX_VERTICES))
        else $error("vertex count beyond limit");

endmodule

// File: design/two_bone_vertex_skinning.sv
// A deformed vertex is blended and transformed from queue head to output register;
// a last vertex adds bit-serial averaging (48-bit restoring divide).
// The back end takes a new request only when done with the last; a deformed vertex is
// paced by 36 table reads and 9 products through the single shared multiplier.
// A 2-entry request queue lets input be taken while the back end works or stalls.
// Reset (i_rst_n low, synchronous) clears sums, count, enable and handshakes.
module two_bone_vertex_skinning (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // word_index, word_value, weight_a, weight_b, bone_a, bone_b, pos_x, pos_y, pos_z
    input  logic [tbvs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // kind
    input  logic                               s_axis_tuser,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_x, out_y, out_z, avg_x, avg_y, avg_z
    output logic [tbvs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // avg_valid, deformed
    output logic [tbvs_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

    logic            q_valid, q_pop;
    tbvs_pkg::t_item q_item;

    tbvs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item),
        .i_q_pop       (q_pop)
    );

    tbvs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// File: tb/skin_checker.sv
`timescale 1ns / 1ps

module skin_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [tbvs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tlast,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [tbvs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic [tbvs_pkg::OUT_USER_W-1:0] m_axis_tuser,
    output int                              o_errors,
    output int                              o_pending
);

    // user bit 0: avg_valid, bit 1: deformed
    typedef struct packed {
        logic [tbvs_pkg::OUT_USER_W-1:0] user;
        logic [tbvs_pkg::OUT_DATA_W-1:0] data;
    } t_skin_result;

    logic [31:0]        bone_words [tbvs_pkg::TABLE_WORDS];
    logic               enabled;
    longint             acc_x, acc_y, acc_z;
    int                 verts;
    t_skin_result       expected_q [$];

    assign o_pending = expected_q.size();

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint word_at(input int slot, input int e);
        return longint'($signed(bone_words[slot * tbvs_pkg::SLOT_WORDS + e]));
    endfunction

    function automatic longint rounded_mean(input longint s, input int n);
        longint mag;
        longint q;
        if (n == 0) return 0;
        mag = s < 0 ? -s : s;
        q = (mag + n / 2) / n;
        return s < 0 ? -q : q;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        o_errors++;
    endtask

    task automatic skin_vertex(input logic [tbvs_pkg::IN_DATA_W-1:0] d, input logic last);
        longint wa, wb, wd, p[3], r[3], avg[3], blend[12], acc, hi, lo, prod;
        int ba, bb;
        t_skin_result res;
        p[0] = longint'($signed(d[116:85]));
        p[1] = longint'($signed(d[148:117]));
        p[2] = longint'($signed(d[180:149]));
        avg = '{0, 0, 0};
        res.user = '0;
        if (!enabled) begin
            r = p;
            if (last) begin
                acc_x = 0; acc_y = 0; acc_z = 0; verts = 0;
            end
        end else begin
            res.user[1] = 1'b1;
            wa = d[57:41] > 65536 ? 65536 : d[57:41];
            wb = d[74:58] > 65536 ? 65536 : d[74:58];
            wd = 65536 - wa - wb;
            ba = d[79:75] >= tbvs_pkg::NUM_BONES ? tbvs_pkg::NUM_BONES : d[79:75];
            bb = d[84:80] >= tbvs_pkg::NUM_BONES ? tbvs_pkg::NUM_BONES : d[84:80];
            for (int e = 0; e < 12; e++) begin
                acc = 0;
                if (wa != 0) acc += wa * word_at(ba, e);
                if (wb != 0) acc += wb * word_at(bb, e);
                if (wd != 0) acc += wd * word_at(tbvs_pkg::NUM_BONES, e);
                blend[e] = clip32((acc + 32768) >>> 16);
            end
            for (int row = 0; row < 3; row++) begin
                hi = 0; lo = 0;
                for (int c = 0; c < 3; c++) begin
                    prod = blend[row * 4 + c] * p[c];
                    hi += prod >>> 16;
                    lo += prod & 64'hFFFF;
                end
                hi += (lo + 32768) >>> 16;
                r[row] = clip32(hi + blend[row * 4 + 3]);
            end
            if (verts < tbvs_pkg::MAX_VERTICES) begin
                acc_x += r[0]; acc_y += r[1]; acc_z += r[2];
                verts++;
            end
            if (last) begin
                res.user[0] = 1'b1;
                avg[0] = clip32(rounded_mean(acc_x, verts));
                avg[1] = clip32(rounded_mean(acc_y, verts));
                avg[2] = clip32(rounded_mean(acc_z, verts));
                acc_x = 0; acc_y = 0; acc_z = 0; verts = 0;
            end
        end
        res.data = {avg[2][31:0], avg[1][31:0], avg[0][31:0],
                    r[2][31:0], r[1][31:0], r[0][31:0]};
        expected_q.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_skin_result want;
        if (!i_rst_n) begin
            enabled = 1'b0;
            acc_x = 0; acc_y = 0; acc_z = 0; verts = 0;
            for (int k = 0; k < tbvs_pkg::TABLE_WORDS; k++) bone_words[k] = '0;
        end else begin
            if (i_cfg_we) enabled = i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == tbvs_pkg::KIND_LOAD) begin
                    if (s_axis_tdata[8:0] < tbvs_pkg::TABLE_WORDS)
                        bone_words[s_axis_tdata[8:0]] = s_axis_tdata[40:9];
                end else begin
                    skin_vertex(s_axis_tdata, s_axis_tlast);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", 64'(m_axis_tdata[31:0]), 0);
                end else begin
                    want = expected_q.pop_front();
                    for (int f = 0; f < 6; f++)
                        if (m_axis_tdata[f*32 +: 32] !== want.data[f*32 +: 32])
                            report_mismatch($sformatf("data field %0d", f),
                                64'(m_axis_tdata[f*32 +: 32]), 64'(want.data[f*32 +: 32]));
                    if (m_axis_tuser[0] !== want.user[0])
                        report_mismatch("avg_valid", 64'(m_axis_tuser[0]), 64'(want.user[0]));
                    if (m_axis_tuser[1] !== want.user[1])
                        report_mismatch("deformed", 64'(m_axis_tuser[1]), 64'(want.user[1]));
                end
            end
        end
    end

    initial o_errors = 0;
endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT = 20000;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic                            i_cfg_wdata = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // word_index, word_value, weight_a, weight_b, bone_a, bone_b, pos_x, pos_y, pos_z
    logic [tbvs_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    // kind
    logic                            s_axis_tuser = 1'b0;
    logic                            s_axis_tlast = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // out_x, out_y, out_z, avg_x, avg_y, avg_z
    logic [tbvs_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    // avg_valid, deformed
    logic [tbvs_pkg::OUT_USER_W-1:0] m_axis_tuser;

    int  errors, pending, idle_cycles;
    bit  quiet;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    two_bone_vertex_skinning dut (.*);

    skin_checker checker_i (.*, .o_errors(errors), .o_pending(pending));

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        int stall;
        if (quiet || $urandom_range(0, 3) != 0) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b0;
            stall = $urandom_range(1, 10);
            repeat (stall - 1) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("two_bone_vertex_skinning test failed");
            $finish;
        end
    end

    task automatic send_request(input logic kind, input logic [tbvs_pkg::IN_DATA_W-1:0] d,
                                input logic last);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= d;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic load_word(input int idx, input logic [31:0] v);
        send_request(tbvs_pkg::KIND_LOAD, tbvs_pkg::IN_DATA_W'({v, 9'(idx)}), 1'b0);
    endtask

    task automatic send_vertex(input logic [16:0] wa, input logic [16:0] wb,
                               input logic [4:0] ba, input logic [4:0] bb,
                               input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic last);
        send_request(tbvs_pkg::KIND_VERTEX,
                     tbvs_pkg::IN_DATA_W'({z, y, x, bb, ba, wb, wa, 32'($urandom),
                                           9'($urandom)}),
                     last);
    endtask

    // small matrices keep results away from saturation most of the time
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h0001_0000;
            default: return 32'($signed($urandom_range(0, 262143)) - 131072);
        endcase
    endfunction

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return 17'($urandom);
            1: return 17'd0;
            2: return 17'd65536;
            default: return 17'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [31:0] rand_pos();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endfunction

    // vertices only use the slots that get loaded
    function automatic logic [4:0] rand_bone();
        if ($urandom_range(0, 8) == 0) return 5'd31;
        return 5'($urandom_range(0, 7));
    endfunction

    task automatic set_enable(input logic v);
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (120) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        quiet = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // slots 0..7, slot 31 and the default slot
        for (int k = 0; k < tbvs_pkg::TABLE_WORDS; k++)
            if (k / tbvs_pkg::SLOT_WORDS < 8 || k / tbvs_pkg::SLOT_WORDS >= 31)
                load_word(k, (k % 5 == 0) ? 32'h0001_0000 : 32'h0);
        set_enable(1'b0);
        // disabled pass-through, including a hull end
        send_vertex(17'd65536, 17'd0, 5'd0, 5'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
        send_vertex(17'h1FFFF, 17'h1FFFF, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'h1, 32'h5, 1'b1);
        set_enable(1'b1);
        // ignored loads beyond the table, then extreme words
        load_word(511, 32'hFFFF_FFFF);
        load_word(396, 32'h1234_5678);
        load_word(0, 32'h7FFF_FFFF);
        load_word(12, 32'h8000_0000);
        send_vertex(17'd65536, 17'd0, 5'd0, 5'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
        send_vertex(17'd65536, 17'd65536, 5'd0, 5'd1, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'hFFFF_FFFF, 1'b0);
        send_vertex(17'h1FFFF, 17'd0, 5'd31, 5'd2, 32'h0001_0000, 32'h0, 32'h0, 1'b0);
        send_vertex(17'd0, 17'd0, 5'd2, 5'd3, 32'h0003_0000, 32'hFFFF_0000, 32'h1, 1'b1);
        send_vertex(17'd32768, 17'd16384, 5'd4, 5'd5, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1);
        // count saturation: a long hull past the vertex limit
        for (int v = 0; v < tbvs_pkg::MAX_VERTICES + 3; v++)
            send_vertex(rand_weight(), rand_weight(), rand_bone(), rand_bone(),
                        rand_pos(), rand_pos(), rand_pos(),
                        v == tbvs_pkg::MAX_VERTICES + 2);
        for (int ph = 0; ph < 4; ph++) begin
            set_enable(ph != 2);
            repeat (15) load_word($urandom_range(0, tbvs_pkg::TABLE_WORDS - 1), rand_word());
            if ($urandom_range(0, 3) == 0) load_word($urandom_range(396, 511), $urandom);
            repeat (45) send_vertex(rand_weight(), rand_weight(), rand_bone(),
                                    rand_bone(), rand_pos(), rand_pos(), rand_pos(),
                                    $urandom_range(0, 7) == 0);
            if (ph == 2) quiet = 1'b1;
        end
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("two_bone_vertex_skinning test passed");
        else
            $display("two_bone_vertex_skinning test failed");
        $finish;
    end
endmodule
